### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
// Every macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define LCDT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("lcdt invariant violated");

// Checks that a condition in one cycle is followed by a consequence in the next.
`define LCDT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcdt sequence violated");

`endif

### hw/rtl/lcdt_pkg.sv
// Shared types, register addresses and default sizes for the LCD line timing unit.
// No dependencies; every RTL module imports this package.
package lcdt_pkg;

	localparam int DEF_TOTAL_LINES   = 154;
	localparam int DEF_VISIBLE_LINES = 144;
	localparam int DEF_DOTS_PER_LINE = 4 * 114;
	localparam int DEF_SEARCH_DOTS   = 80;
	localparam int DEF_TRANSFER_DOTS = 172;
	localparam int DEF_PALETTE_BYTES = 64;

	localparam int LINE_W      = 8;
	localparam int DOT_W       = 9;
	localparam int POS_W       = 10;
	localparam int TICK_W      = 7;
	localparam int STORE_IDX_W = 6;

	localparam logic [TICK_W-1:0] CHUNK_DOTS = 7'd80;

	localparam int EN_MODE0 = 0;
	localparam int EN_MODE1 = 1;
	localparam int EN_MODE2 = 2;
	localparam int EN_LYC   = 3;

	localparam logic [15:0] ADDR_LCDC = 16'hFF40;
	localparam logic [15:0] ADDR_STAT = 16'hFF41;
	localparam logic [15:0] ADDR_SCY  = 16'hFF42;
	localparam logic [15:0] ADDR_SCX  = 16'hFF43;
	localparam logic [15:0] ADDR_LY   = 16'hFF44;
	localparam logic [15:0] ADDR_LYC  = 16'hFF45;
	localparam logic [15:0] ADDR_BGP  = 16'hFF47;
	localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
	localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
	localparam logic [15:0] ADDR_WY   = 16'hFF4A;
	localparam logic [15:0] ADDR_WX   = 16'hFF4B;
	localparam logic [15:0] ADDR_BCPS = 16'hFF68;
	localparam logic [15:0] ADDR_BCPD = 16'hFF69;
	localparam logic [15:0] ADDR_OCPS = 16'hFF6A;
	localparam logic [15:0] ADDR_OCPD = 16'hFF6B;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_HBLANK   = 2'd0,
		MODE_VBLANK   = 2'd1,
		MODE_SEARCH   = 2'd2,
		MODE_TRANSFER = 2'd3
	} lcd_mode_t;

	typedef enum logic [1:0] {
		RD_SRC_REG,
		RD_SRC_BG,
		RD_SRC_OBJ
	} rd_src_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [15:0]       addr;
		logic [7:0]        wdata;
		logic [TICK_W-1:0] dots;
	} item_t;

	typedef struct packed {
		logic              display_on;
		logic [3:0]        irq_en;
		logic [LINE_W-1:0] lyc;
	} timing_cfg_t;

	typedef struct packed {
		lcd_mode_t         mode;
		logic [LINE_W-1:0] line;
		logic [DOT_W-1:0]  dot;
	} timing_status_t;

	typedef struct packed {
		logic vblank;
		logic stat;
		logic draw;
	} flags_t;

	typedef struct packed {
		logic                   re;
		logic                   we;
		logic [STORE_IDX_W-1:0] idx;
		logic [7:0]             wdata;
	} store_req_t;

endpackage

### hw/rtl/lcdt_timing.sv
// Dot, line and mode counters with the interrupt and draw pulse logic.
// Depends on lcdt_pkg; a tick is handled as up to two chunks of dots.
module lcdt_timing #(
	parameter int TOTAL_LINES   = lcdt_pkg::DEF_TOTAL_LINES,
	parameter int VISIBLE_LINES = lcdt_pkg::DEF_VISIBLE_LINES,
	parameter int DOTS_PER_LINE = lcdt_pkg::DEF_DOTS_PER_LINE,
	parameter int SEARCH_DOTS   = lcdt_pkg::DEF_SEARCH_DOTS,
	parameter int TRANSFER_DOTS = lcdt_pkg::DEF_TRANSFER_DOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick_req,
	input  logic [lcdt_pkg::TICK_W-1:0]    tick_dots,
	input  lcdt_pkg::timing_cfg_t          cfg,
	output lcdt_pkg::timing_status_t       status,
	output lcdt_pkg::flags_t               flags
);
	import lcdt_pkg::*;

	localparam logic [POS_W-1:0]  LINE_DOTS  = POS_W'(DOTS_PER_LINE);
	localparam logic [POS_W-1:0]  SEARCH_END = POS_W'(SEARCH_DOTS);
	localparam logic [POS_W-1:0]  XFER_END   = POS_W'(SEARCH_DOTS + TRANSFER_DOTS);
	localparam logic [LINE_W-1:0] LAST_LINE  = LINE_W'(TOTAL_LINES - 1);
	localparam logic [LINE_W-1:0] VBL_LINE   = LINE_W'(VISIBLE_LINES);

	typedef struct packed {
		lcd_mode_t         mode;
		logic [LINE_W-1:0] line;
		logic [DOT_W-1:0]  dot;
		logic              vb;
		logic              st;
		logic              dl;
	} chunk_t;

	function automatic chunk_t run_chunk(chunk_t cur, logic [TICK_W-1:0] step,
			logic [3:0] en, logic [LINE_W-1:0] lyc);
		chunk_t r;
		logic [POS_W-1:0] pos;
		r = cur;
		pos = {1'b0, cur.dot} + POS_W'(step);
		if (pos >= LINE_DOTS) begin
			pos = pos - LINE_DOTS;
			r.line = (cur.line == LAST_LINE) ? '0 : cur.line + LINE_W'(1);
			if (en[EN_LYC] && r.line == lyc) begin
				r.st = 1'b1;
			end
			if (r.line >= VBL_LINE && r.mode != MODE_VBLANK) begin
				r.mode = MODE_VBLANK;
				r.vb = 1'b1;
				if (en[EN_MODE1]) begin
					r.st = 1'b1;
				end
			end
		end
		r.dot = pos[DOT_W-1:0];
		if (r.line < VBL_LINE) begin
			if (pos < SEARCH_END) begin
				if (r.mode != MODE_SEARCH) begin
					r.mode = MODE_SEARCH;
					if (en[EN_MODE2]) begin
						r.st = 1'b1;
					end
				end
			end else if (pos < XFER_END) begin
				if (r.mode != MODE_TRANSFER) begin
					r.mode = MODE_TRANSFER;
					r.dl = 1'b1;
				end
			end else if (r.mode != MODE_HBLANK) begin
				r.mode = MODE_HBLANK;
				if (en[EN_MODE0]) begin
					r.st = 1'b1;
				end
			end
		end
		return r;
	endfunction

	lcd_mode_t         mode_q;
	logic [LINE_W-1:0] line_q;
	logic [DOT_W-1:0]  dot_q;

	logic              tick_en;
	logic [TICK_W-1:0] step_a;
	logic [TICK_W-1:0] step_b;
	chunk_t            cur;
	chunk_t            after_a;
	chunk_t            after_b;

	always_comb begin
		tick_en = tick_req && cfg.display_on;
		step_a  = (tick_dots >= CHUNK_DOTS) ? CHUNK_DOTS : tick_dots;
		step_b  = tick_dots - step_a;
		cur     = '{mode: mode_q, line: line_q, dot: dot_q, vb: 1'b0, st: 1'b0, dl: 1'b0};
		after_a = (step_a != '0) ? run_chunk(cur, step_a, cfg.irq_en, cfg.lyc) : cur;
		after_b = (step_b != '0) ? run_chunk(after_a, step_b, cfg.irq_en, cfg.lyc) : after_a;
		flags.vblank = tick_en && after_b.vb;
		flags.stat   = tick_en && after_b.st;
		flags.draw   = tick_en && after_b.dl;
		status.mode  = mode_q;
		status.line  = line_q;
		status.dot   = dot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HBLANK;
			line_q <= '0;
			dot_q  <= '0;
		end else if (tick_en) begin
			mode_q <= after_b.mode;
			line_q <= after_b.line;
			dot_q  <= after_b.dot;
		end
	end

endmodule

### hw/rtl/lcdt_regs.sv
// Register file: control, status enables, scroll, window, compare, palettes and store pointers.
// Depends on lcdt_pkg; drives the access requests of the two colour stores.
module lcdt_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  lcdt_pkg::item_t          item,
	input  lcdt_pkg::timing_status_t status,
	output lcdt_pkg::timing_cfg_t    cfg,
	output lcdt_pkg::store_req_t     bg_req,
	output lcdt_pkg::store_req_t     obj_req,
	output logic [7:0]               reg_rd,
	output lcdt_pkg::rd_src_t        rd_src
);
	import lcdt_pkg::*;

	function automatic logic [STORE_IDX_W:0] ptr_after_write(logic [STORE_IDX_W:0] ptr);
		logic [STORE_IDX_W-1:0] idx;
		idx = ptr[STORE_IDX_W-1:0];
		if (ptr[STORE_IDX_W]) begin
			idx = idx + STORE_IDX_W'(1);
		end
		return {ptr[STORE_IDX_W], idx};
	endfunction

	logic [7:0]             control_q;
	logic [3:0]             irq_en_q;
	logic [LINE_W-1:0]      lyc_q;
	logic [7:0]             scy_q;
	logic [7:0]             scx_q;
	logic [7:0]             wy_q;
	logic [7:0]             wx_q;
	logic [7:0]             bgp_q;
	logic [7:0]             obp0_q;
	logic [7:0]             obp1_q;
	logic [STORE_IDX_W:0]   bg_ptr_q;
	logic [STORE_IDX_W:0]   obj_ptr_q;

	logic wr;
	logic rd;

	assign wr = fire && item.cmd == CMD_WRITE;
	assign rd = fire && item.cmd == CMD_READ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
			irq_en_q  <= '0;
			lyc_q     <= '0;
			scy_q     <= '0;
			scx_q     <= '0;
			wy_q      <= '0;
			wx_q      <= '0;
			bgp_q     <= '0;
			obp0_q    <= '0;
			obp1_q    <= '0;
			bg_ptr_q  <= '0;
			obj_ptr_q <= '0;
		end else if (wr) begin
			unique case (item.addr)
				ADDR_LCDC: control_q <= item.wdata;
				ADDR_STAT: irq_en_q  <= item.wdata[6:3];
				ADDR_SCY:  scy_q     <= item.wdata;
				ADDR_SCX:  scx_q     <= item.wdata;
				ADDR_LYC:  lyc_q     <= item.wdata;
				ADDR_BGP:  bgp_q     <= item.wdata;
				ADDR_OBP0: obp0_q    <= item.wdata;
				ADDR_OBP1: obp1_q    <= item.wdata;
				ADDR_WY:   wy_q      <= item.wdata;
				ADDR_WX:   wx_q      <= item.wdata;
				ADDR_BCPS: bg_ptr_q  <= {item.wdata[7], item.wdata[STORE_IDX_W-1:0]};
				ADDR_BCPD: bg_ptr_q  <= ptr_after_write(bg_ptr_q);
				ADDR_OCPS: obj_ptr_q <= {item.wdata[7], item.wdata[STORE_IDX_W-1:0]};
				ADDR_OCPD: obj_ptr_q <= ptr_after_write(obj_ptr_q);
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.display_on = control_q[7];
		cfg.irq_en     = irq_en_q;
		cfg.lyc        = lyc_q;

		bg_req.re     = rd && item.addr == ADDR_BCPD;
		bg_req.we     = wr && item.addr == ADDR_BCPD;
		bg_req.idx    = bg_ptr_q[STORE_IDX_W-1:0];
		bg_req.wdata  = item.wdata;
		obj_req.re    = rd && item.addr == ADDR_OCPD;
		obj_req.we    = wr && item.addr == ADDR_OCPD;
		obj_req.idx   = obj_ptr_q[STORE_IDX_W-1:0];
		obj_req.wdata = item.wdata;

		rd_src = RD_SRC_REG;
		reg_rd = '0;
		if (item.cmd == CMD_READ) begin
			unique case (item.addr)
				ADDR_LCDC: reg_rd = control_q;
				ADDR_STAT: reg_rd = {1'b0, irq_en_q, status.line == lyc_q, status.mode};
				ADDR_SCY:  reg_rd = scy_q;
				ADDR_SCX:  reg_rd = scx_q;
				ADDR_LY:   reg_rd = status.line;
				ADDR_LYC:  reg_rd = lyc_q;
				ADDR_BGP:  reg_rd = bgp_q;
				ADDR_OBP0: reg_rd = obp0_q;
				ADDR_OBP1: reg_rd = obp1_q;
				ADDR_WY:   reg_rd = wy_q;
				ADDR_WX:   reg_rd = wx_q;
				ADDR_BCPD: rd_src = RD_SRC_BG;
				ADDR_OCPD: rd_src = RD_SRC_OBJ;
				default:   reg_rd = '0;
			endcase
		end
	end

endmodule

### hw/rtl/lcdt_cstore.sv
// Colour palette store: a byte memory with a registered read port.
// Depends on lcdt_pkg; per-entry valid bits make unwritten entries read as zero.
module lcdt_cstore #(
	parameter int PALETTE_BYTES = lcdt_pkg::DEF_PALETTE_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcdt_pkg::store_req_t req,
	output logic [7:0]           rd_data
);
	import lcdt_pkg::*;

	localparam int AW = $clog2(PALETTE_BYTES);

	logic [7:0]               mem [PALETTE_BYTES];
	logic [PALETTE_BYTES-1:0] valid_q;
	logic [7:0]               data_q;
	logic                     hit_q;
	logic                     in_range;
	logic [AW-1:0]            addr;

	assign in_range = (STORE_IDX_W + 1)'(req.idx) < (STORE_IDX_W + 1)'(PALETTE_BYTES);
	assign addr     = req.idx[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.we && in_range) begin
			mem[addr] <= req.wdata;
		end
		if (req.re) begin
			data_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (req.we && in_range) begin
				valid_q[addr] <= 1'b1;
			end
			if (req.re) begin
				hit_q <= in_range && valid_q[addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

### hw/rtl/lcd_line_timing_and_registers_unit.sv
// Top level of the LCD line timing and register unit: input register, result register.
// Depends on lcdt_pkg, lcdt_timing, lcdt_regs, lcdt_cstore and assert_macros.svh.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    cmd, reg_addr, write_data, tick_dots
//   out      out_valid / out_stall  read_data, vblank_irq, stat_irq, draw_line
//
// Every item passes through the input register and then the result register.
// Throughput is one item per cycle while the result is not stalled; the dot, line and mode update is combinational.
// Reset clears the control and counter registers; both colour stores read as zero until written.
// A stalled result holds the input register, which then stalls the input.
module lcd_line_timing_and_registers_unit #(
	parameter int TOTAL_LINES   = lcdt_pkg::DEF_TOTAL_LINES,
	parameter int VISIBLE_LINES = lcdt_pkg::DEF_VISIBLE_LINES,
	parameter int DOTS_PER_LINE = lcdt_pkg::DEF_DOTS_PER_LINE,
	parameter int SEARCH_DOTS   = lcdt_pkg::DEF_SEARCH_DOTS,
	parameter int TRANSFER_DOTS = lcdt_pkg::DEF_TRANSFER_DOTS,
	parameter int PALETTE_BYTES = lcdt_pkg::DEF_PALETTE_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [15:0]                 reg_addr,
	input  logic [7:0]                  write_data,
	input  logic [lcdt_pkg::TICK_W-1:0] tick_dots,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  read_data,
	output logic                        vblank_irq,
	output logic                        stat_irq,
	output logic                        draw_line
);
	import lcdt_pkg::*;

	`include "assert_macros.svh"

	localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(TOTAL_LINES);
	localparam logic [LINE_W-1:0] VBL_LINE   = LINE_W'(VISIBLE_LINES);
	localparam logic [DOT_W-1:0]  DOT_LIMIT  = DOT_W'(DOTS_PER_LINE);

	item_t          item_s1;
	logic           valid_s1;
	logic           out_valid_q;
	logic           fire;

	timing_cfg_t    cfg;
	timing_status_t status;
	flags_t         flags;
	flags_t         flags_q;
	store_req_t     bg_req;
	store_req_t     obj_req;
	logic [7:0]     reg_rd;
	logic [7:0]     reg_rd_q;
	rd_src_t        rd_src;
	rd_src_t        rd_src_q;
	logic [7:0]     bg_rd;
	logic [7:0]     obj_rd;

	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{cmd: cmd, addr: reg_addr, wdata: write_data, dots: tick_dots};
		end
	end

	lcdt_timing #(
		.TOTAL_LINES  (TOTAL_LINES),
		.VISIBLE_LINES(VISIBLE_LINES),
		.DOTS_PER_LINE(DOTS_PER_LINE),
		.SEARCH_DOTS  (SEARCH_DOTS),
		.TRANSFER_DOTS(TRANSFER_DOTS)
	) u_timing (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick_req (fire && item_s1.cmd == CMD_TICK),
		.tick_dots(item_s1.dots),
		.cfg      (cfg),
		.status   (status),
		.flags    (flags)
	);

	lcdt_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.status (status),
		.cfg    (cfg),
		.bg_req (bg_req),
		.obj_req(obj_req),
		.reg_rd (reg_rd),
		.rd_src (rd_src)
	);

	lcdt_cstore #(
		.PALETTE_BYTES(PALETTE_BYTES)
	) u_bg_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bg_req),
		.rd_data(bg_rd)
	);

	lcdt_cstore #(
		.PALETTE_BYTES(PALETTE_BYTES)
	) u_obj_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (obj_req),
		.rd_data(obj_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			flags_q  <= flags;
			reg_rd_q <= reg_rd;
			rd_src_q <= rd_src;
		end
	end

	always_comb begin
		case (rd_src_q)
			RD_SRC_BG:  read_data = bg_rd;
			RD_SRC_OBJ: read_data = obj_rd;
			default:    read_data = reg_rd_q;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign vblank_irq = flags_q.vblank;
	assign stat_irq   = flags_q.stat;
	assign draw_line  = flags_q.draw;

	`LCDT_NEXT(a_flags_only_on_tick, fire && item_s1.cmd != CMD_TICK, !vblank_irq && !stat_irq && !draw_line)
	`LCDT_ALWAYS(a_line_in_frame, status.line < LINE_LIMIT && (status.line < VBL_LINE || status.mode == MODE_VBLANK))
	`LCDT_ALWAYS(a_dot_in_line, status.dot < DOT_LIMIT)

endmodule
